>>> sv/tea_encrypt_padded_byte_macros.svh
// ----------------------------------------------------------------------------
// TEA padded-byte encryptor assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TEA_ENCRYPT_PADDED_BYTE_MACROS_SVH
`define TEA_ENCRYPT_PADDED_BYTE_MACROS_SVH

// Same-cycle implication.
`define TEA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TEA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/tea_pkg.sv
// ----------------------------------------------------------------------------
// TEA padded-byte encryptor package
// Cipher constants, key register indexes and the round mixing function.
// ----------------------------------------------------------------------------
package tea_pkg;

  localparam logic [31:0] TEA_DELTA = 32'h9E37_79B9;
  localparam logic [31:0] PAD_WORD  = 32'h0707_0707;
  localparam logic [31:0] KEY_RESET = 32'h0000_0031;

  localparam int KEY_IDX_W = 2;

  typedef logic [KEY_IDX_W-1:0] key_idx_t;

  localparam key_idx_t KEY_IDX_ZERO  = 2'd0;
  localparam key_idx_t KEY_IDX_ONE   = 2'd1;
  localparam key_idx_t KEY_IDX_TWO   = 2'd2;
  localparam key_idx_t KEY_IDX_THREE = 2'd3;

  function automatic logic [31:0] mix_word(
    input logic [31:0] w,
    input logic [31:0] ka,
    input logic [31:0] kb,
    input logic [31:0] sum
  );
    logic [31:0] left_part;
    logic [31:0] right_part;
    left_part  = {w[27:0], 4'b0000} + ka;
    right_part = {5'b00000, w[31:5]} + kb;
    return left_part ^ (w + sum) ^ right_part;
  endfunction

endpackage

>>> sv/tea_byte_if.sv
// ----------------------------------------------------------------------------
// Plaintext byte channel
// Valid/ready stream carrying one plaintext byte per transfer.
// ----------------------------------------------------------------------------
interface tea_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] plain_byte;

  modport source (output valid, output plain_byte, input ready);
  modport sink (input valid, input plain_byte, output ready);
endinterface

>>> sv/tea_block_if.sv
// ----------------------------------------------------------------------------
// Ciphertext block channel
// Valid/ready stream carrying one 64-bit ciphertext block per transfer.
// ----------------------------------------------------------------------------
interface tea_block_if;
  logic        valid;
  logic        ready;
  logic [63:0] cipher_block;

  modport source (output valid, output cipher_block, input ready);
  modport sink (input valid, input cipher_block, output ready);
endinterface

>>> sv/tea_cfg_if.sv
// ----------------------------------------------------------------------------
// Key configuration channel
// Valid/ready write channel carrying a key register index and write data.
// ----------------------------------------------------------------------------
interface tea_cfg_if;
  logic              valid;
  logic              ready;
  tea_pkg::key_idx_t index;
  logic [31:0]       data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/tea_encrypt_padded_byte.sv
// ----------------------------------------------------------------------------
// TEA padded-byte encryptor
// Pads each plaintext byte into a 64-bit block and runs TEA encryption rounds.
// ----------------------------------------------------------------------------
// Channels: plain takes one byte per transfer, cipher gives one 64-bit block
// per byte (v1 in bits 63:32, v0 in bits 31:0), in order. cfg writes the four
// 32-bit key words at indexes 0..3; it is always ready. The user must write it
// only while no byte is in flight; the block does not enforce this.
// Pipeline: 2*ROUND_COUNT register stages, each one TEA half-round (one
// word update of shift, add and xor). A byte accepted at an edge moves
// through the stages in order and is offered on cipher from the last one.
// One byte is accepted per cycle while the skid register is empty.
// Stall: a skid register behind the last stage catches the result that the
// receiver refuses; the pipeline and plain.ready hold while it is full, so
// one byte is still taken in the first stalled cycle and nothing is lost.
// Reset: clears all stage valid bits and the skid valid bit and loads every
// key word with 0x31. Latency and rate need no warm-up after reset.
// ----------------------------------------------------------------------------
`include "tea_encrypt_padded_byte_macros.svh"

module tea_encrypt_padded_byte #(
  parameter int ROUND_COUNT = 32
) (
  input  logic        clk,
  input  logic        rst,
  tea_cfg_if.sink     cfg,
  tea_byte_if.sink    plain,
  tea_block_if.source cipher
);

  localparam int STAGES = 2 * ROUND_COUNT;
  localparam int LAST   = STAGES - 1;

  logic [31:0] key_word_zero;
  logic [31:0] key_word_one;
  logic [31:0] key_word_two;
  logic [31:0] key_word_three;

  logic [STAGES-1:0] pipe_valid;
  logic [31:0]       v0 [STAGES];
  logic [31:0]       v1 [STAGES];

  logic        skid_valid;
  logic [63:0] skid_block;
  logic        advance;
  logic        plain_xfer;

  // Key registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_word_zero  <= tea_pkg::KEY_RESET;
      key_word_one   <= tea_pkg::KEY_RESET;
      key_word_two   <= tea_pkg::KEY_RESET;
      key_word_three <= tea_pkg::KEY_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        tea_pkg::KEY_IDX_ZERO:  key_word_zero  <= cfg.data;
        tea_pkg::KEY_IDX_ONE:   key_word_one   <= cfg.data;
        tea_pkg::KEY_IDX_TWO:   key_word_two   <= cfg.data;
        tea_pkg::KEY_IDX_THREE: key_word_three <= cfg.data;
        default:                key_word_zero  <= key_word_zero;
      endcase
    end
  end

  // Input side
  assign advance     = !skid_valid;
  assign plain.ready = advance;
  assign plain_xfer  = plain.valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= '0;
    end else if (advance) begin
      pipe_valid <= {pipe_valid[STAGES-2:0], plain_xfer};
    end
  end

  // Half-round stages
  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam int          ROUND    = s / 2;
    localparam logic [63:0] SUM_WIDE = 64'(ROUND + 1) * 64'(tea_pkg::TEA_DELTA);
    localparam logic [31:0] SUM      = SUM_WIDE[31:0];

    logic [31:0] in_v0;
    logic [31:0] in_v1;

    if (s == 0) begin : g_pad
      assign in_v0 = {tea_pkg::PAD_WORD[31:8], plain.plain_byte};
      assign in_v1 = tea_pkg::PAD_WORD;
    end else begin : g_chain
      assign in_v0 = v0[s-1];
      assign in_v1 = v1[s-1];
    end

    if (s % 2 == 0) begin : g_upd_v0
      always_ff @(posedge clk) begin
        if (advance) begin
          v0[s] <= in_v0 + tea_pkg::mix_word(in_v1, key_word_zero, key_word_one, SUM);
          v1[s] <= in_v1;
        end
      end
    end else begin : g_upd_v1
      always_ff @(posedge clk) begin
        if (advance) begin
          v0[s] <= in_v0;
          v1[s] <= in_v1 + tea_pkg::mix_word(in_v0, key_word_two, key_word_three, SUM);
        end
      end
    end
  end

  // Output side with skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (cipher.ready) begin
        skid_valid <= 1'b0;
      end
    end else if (pipe_valid[LAST] && !cipher.ready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid) begin
      skid_block <= {v1[LAST], v0[LAST]};
    end
  end

  assign cipher.valid        = skid_valid || pipe_valid[LAST];
  assign cipher.cipher_block = skid_valid ? skid_block : {v1[LAST], v0[LAST]};

  // Checks
  `TEA_ASSERT_NEXT(a_enter_stage0, plain.valid && plain.ready, pipe_valid[0],
    "accepted byte did not enter the first stage")
  `TEA_ASSERT_NEXT(a_stall_to_skid, !skid_valid && pipe_valid[LAST] && !cipher.ready,
    skid_valid, "refused result was not caught by the skid register")
  `TEA_ASSERT_NEXT(a_skid_hold, skid_valid && !cipher.ready,
    skid_valid && $stable(skid_block), "skid register changed while stalled")
  `TEA_ASSERT_NEXT(a_pipe_freeze, skid_valid, $stable(pipe_valid),
    "pipeline moved while the skid register was full")

endmodule

>>> bench/tea_encrypt_padded_byte_checker.sv
// ----------------------------------------------------------------------------
// TEA padded-byte encryptor checker
// Watches the key, plaintext and ciphertext channels, keeps its own copy of
// the key words, encrypts every accepted byte and compares each ciphertext
// transfer in order against the oldest predicted block.
// ----------------------------------------------------------------------------
module tea_encrypt_padded_byte_checker #(
  parameter int ROUND_COUNT = 32
) (
  input  logic clk,
  input  logic rst,
  tea_cfg_if   cfg,
  tea_byte_if  plain,
  tea_block_if cipher,
  output int   mismatches,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0]  plain_byte;
    logic [63:0] cipher_block;
  } pending_block_t;

  logic [31:0]    key_words [4];
  pending_block_t pending_blocks [$];
  int             fail_count;

  function automatic logic [63:0] encrypt_byte(input logic [7:0] plain_byte);
    logic [31:0] v0;
    logic [31:0] v1;
    logic [31:0] round_sum;
    v0        = {tea_pkg::PAD_WORD[31:8], plain_byte};
    v1        = tea_pkg::PAD_WORD;
    round_sum = '0;
    for (int r = 0; r < ROUND_COUNT; r++) begin
      round_sum = round_sum + tea_pkg::TEA_DELTA;
      v0 = v0 + (((v1 << 4) + key_words[tea_pkg::KEY_IDX_ZERO]) ^ (v1 + round_sum)
                 ^ ((v1 >> 5) + key_words[tea_pkg::KEY_IDX_ONE]));
      v1 = v1 + (((v0 << 4) + key_words[tea_pkg::KEY_IDX_TWO]) ^ (v0 + round_sum)
                 ^ ((v0 >> 5) + key_words[tea_pkg::KEY_IDX_THREE]));
    end
    return {v1, v0};
  endfunction

  initial begin
    fail_count = 0;
  end

  always @(posedge clk) begin : watch
    pending_block_t head;
    pending_block_t fresh;
    if (rst) begin
      for (int i = 0; i < 4; i++) key_words[i] = tea_pkg::KEY_RESET;
      pending_blocks.delete();
    end else begin
      if (cipher.valid && cipher.ready) begin
        if (pending_blocks.size() == 0) begin
          fail_count++;
          $display("%0t cipher transfer with none expected: expected none, actual %h",
                   $time, cipher.cipher_block);
        end else begin
          head = pending_blocks.pop_front();
          if (cipher.cipher_block !== head.cipher_block) begin
            fail_count++;
            $display("%0t cipher mismatch for byte %h: expected %h, actual %h",
                     $time, head.plain_byte, head.cipher_block, cipher.cipher_block);
          end
        end
      end
      if (plain.valid && plain.ready) begin
        fresh.plain_byte   = plain.plain_byte;
        fresh.cipher_block = encrypt_byte(plain.plain_byte);
        pending_blocks.push_back(fresh);
      end
      if (cfg.valid && cfg.ready) key_words[cfg.index] = cfg.data;
    end
    mismatches  <= fail_count;
    outstanding <= pending_blocks.size();
  end

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// TEA padded-byte encryptor testbench
// Drives plaintext bytes and key writes into the encryptor under random
// source gaps and sink stalls, including one long sink hold-off that backs
// the pipeline up, and judges by the checker's failure and outstanding counts.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROUND_COUNT = 32;
  localparam int LATENCY     = 2 * ROUND_COUNT;
  localparam int HOLD_CYCLES = 400;

  localparam tea_pkg::key_idx_t KEY_ORDER [4] = '{tea_pkg::KEY_IDX_ZERO,
                                                  tea_pkg::KEY_IDX_ONE,
                                                  tea_pkg::KEY_IDX_TWO,
                                                  tea_pkg::KEY_IDX_THREE};

  logic clk = 1'b0;
  logic rst;
  int   mismatches;
  int   outstanding;
  bit   gaps_on;
  bit   stalls_on;
  bit   hold_off_pending;

  tea_cfg_if   cfg ();
  tea_byte_if  plain ();
  tea_block_if cipher ();

  tea_encrypt_padded_byte #(
    .ROUND_COUNT(ROUND_COUNT)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .plain (plain),
    .cipher(cipher)
  );

  tea_encrypt_padded_byte_checker #(
    .ROUND_COUNT(ROUND_COUNT)
  ) checker_i (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .plain      (plain),
    .cipher     (cipher),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // sink side: random stalls and one long hold-off on request
  initial begin
    cipher.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        cipher.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (stalls_on && $urandom_range(0, 2) == 0) begin
        cipher.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      cipher.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] plain_byte);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      plain.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    plain.valid      <= 1'b1;
    plain.plain_byte <= plain_byte;
    do @(posedge clk); while (!plain.ready);
  endtask

  task automatic drain();
    plain.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_keys(input logic [31:0] words [4], input logic [3:0] mask);
    for (int i = 0; i < 4; i++) begin
      if (mask[i]) begin
        cfg.valid <= 1'b1;
        cfg.index <= KEY_ORDER[i];
        cfg.data  <= words[i];
        do @(posedge clk); while (!cfg.ready);
      end
    end
    cfg.valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_key();
    unique case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_phase(input int count);
    logic [31:0] words [4];
    for (int i = 0; i < 4; i++) words[i] = pick_key();
    write_keys(words, 4'($urandom_range(1, 15)));
    for (int n = 0; n < count; n++) send_byte(8'($urandom_range(0, 255)));
    drain();
  endtask

  initial begin
    logic [31:0] words [4];
    logic [7:0]  reset_key_bytes [9];
    reset_key_bytes  = '{8'h00, 8'hFF, 8'h07, 8'h01, 8'h80, 8'h55,
                         8'hAA, 8'h7F, 8'hFE};
    rst              <= 1'b1;
    plain.valid      <= 1'b0;
    plain.plain_byte <= '0;
    cfg.valid        <= 1'b0;
    cfg.index        <= tea_pkg::KEY_IDX_ZERO;
    cfg.data         <= '0;
    gaps_on          = 1'b1;
    stalls_on        = 1'b1;
    hold_off_pending = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (reset_key_bytes[i]) send_byte(reset_key_bytes[i]);
    drain();

    words = '{32'h0, 32'h0, 32'h0, 32'h0};
    write_keys(words, 4'b1111);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h5A);
    drain();

    words = '{'1, '1, '1, '1};
    write_keys(words, 4'b1111);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hA5);
    drain();

    words = '{32'h0, 32'h0, 32'hAAAA_AAAA, 32'h5555_5555};
    write_keys(words, 4'b1100);
    send_byte(8'h00);
    send_byte(8'hFF);
    drain();

    for (int p = 0; p < 5; p++) run_phase(100);

    gaps_on          = 1'b0;
    hold_off_pending = 1'b1;
    run_phase(150);

    stalls_on = 1'b0;
    run_phase(100);

    repeat (LATENCY + 8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
